// ===== hw/rtl/atts_pkg.sv =====
// shared widths, segment codes and digit decoder for the temperature display block
`timescale 1ns / 1ps

package atts_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TEMP_W   = 12;
  localparam int SEG_W    = 8;
  localparam int DIGIT_W  = 4;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h02;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h01;

  // segments a..g on bits 7..1, decimal point on bit 0
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hDA;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hF6;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/atts_if.sv =====
// valid/ready stream interfaces for converter samples and display transactions
`timescale 1ns / 1ps

interface atts_sample_if;
  logic                          valid;
  logic                          ready;
  logic [atts_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface atts_display_if;
  logic                              valid;
  logic                              ready;
  logic signed [atts_pkg::TEMP_W-1:0] temperature_tenths;
  logic [atts_pkg::SEG_W-1:0]        digit0_segments;
  logic [atts_pkg::SEG_W-1:0]        digit1_segments;
  logic [atts_pkg::SEG_W-1:0]        digit2_segments;
  logic [atts_pkg::SEG_W-1:0]        digit3_segments;

  modport source (
    output valid, output temperature_tenths,
    output digit0_segments, output digit1_segments,
    output digit2_segments, output digit3_segments,
    input  ready
  );
  modport sink (
    input  valid, input temperature_tenths,
    input  digit0_segments, input digit1_segments,
    input  digit2_segments, input digit3_segments,
    output ready
  );
endinterface

// ===== hw/rtl/adc_to_temperature_segments_core.sv =====
// converter sample to tenths of a degree and four seven-segment digits
`timescale 1ns / 1ps

// Takes one 10-bit converter sample per transaction and returns one display
// transaction: the temperature in tenths of a degree (two's complement,
// -611..1606) and the segment patterns of four digits, right-justified signed
// decimal with a minus sign ahead of the digits, a leading '0' for single-digit
// values and the decimal point lit on the third digit. The datapath is a
// seven-stage pipeline: a sample enters every clock cycle while the sink keeps
// ready high, and its result passes through each stage register in turn to the
// display channel. Each stage holds its own valid bit and stalls only
// when the stage after it is full and stalled, so backpressure fills bubbles
// and nothing is dropped or repeated. The stages are: scale to v and offset,
// multiply by 40 and reciprocal estimate of the divide by nine, quotient fix
// and offset by -500, magnitude and thousands digit, hundreds digit, tens and
// units digits, segment formatting into the output register.
module adc_to_temperature_segments_core (
  input  logic                   clk,
  input  logic                   rst,
  atts_sample_if.sink            adc,
  atts_display_if.source         display
);
  import atts_pkg::*;

  localparam int STAGES = 7;
  localparam int LAST   = STAGES - 1;
  localparam int DIGITS = 4;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd611;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1606;

  // per-stage occupancy and load enables
  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] advance;

  always_comb begin
    advance[LAST] = !valid[LAST] || display.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      advance[k] = !valid[k] || advance[k+1];
    end
  end

  assign adc.ready = advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (advance[0]) begin
        valid[0] <= adc.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (advance[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // stage 0: v = sample*500/1024, then |v-25| and its sign
  logic [18:0] s0_prod;
  logic [8:0]  s0_v;
  logic        s0_neg_c;
  logic [8:0]  s0_ax_c;
  logic        s0_neg;
  logic [8:0]  s0_ax;

  always_comb begin
    s0_prod  = 19'(adc.adc_sample) * 19'd500;
    s0_v     = s0_prod[18:10];
    s0_neg_c = s0_v < 9'd25;
    s0_ax_c  = s0_neg_c ? (9'd25 - s0_v) : (s0_v - 9'd25);
  end

  always_ff @(posedge clk) begin
    if (advance[0]) begin
      s0_neg <= s0_neg_c;
      s0_ax  <= s0_ax_c;
    end
  end

  // stage 1: m = |x|*40, low estimate of m/9 through a 16-bit reciprocal
  logic [14:0] s1_m_c;
  logic [27:0] s1_qprod;
  logic        s1_neg;
  logic [14:0] s1_m;
  logic [11:0] s1_q0;

  always_comb begin
    s1_m_c   = (15'(s0_ax) << 5) + (15'(s0_ax) << 3);
    s1_qprod = 28'(s1_m_c) * 28'd7281;
  end

  always_ff @(posedge clk) begin
    if (advance[1]) begin
      s1_neg <= s0_neg;
      s1_m   <= s1_m_c;
      s1_q0  <= s1_qprod[27:16];
    end
  end

  // stage 2: the estimate is short by at most one, then sign and offset
  logic [15:0]               s2_rem;
  logic [11:0]               s2_q;
  logic signed [TEMP_W:0]    s2_sq;
  logic signed [TEMP_W:0]    s2_t13;
  logic signed [TEMP_W-1:0]  s2_t;

  always_comb begin
    s2_rem = 16'(s1_m) - 16'(16'(s1_q0) * 16'd9);
    s2_q   = s1_q0 + 12'(s2_rem >= 16'd9);
    s2_sq  = s1_neg ? (13'sd0 - $signed({1'b0, s2_q})) : $signed({1'b0, s2_q});
    s2_t13 = s2_sq - 13'sd500;
  end

  always_ff @(posedge clk) begin
    if (advance[2]) begin
      s2_t <= s2_t13[TEMP_W-1:0];
    end
  end

  // stage 3: magnitude, thousands digit, digit count
  logic [TEMP_W-1:0]         s3_mag12;
  logic [10:0]               s3_mag;
  logic                      s3_thou_c;
  logic [1:0]                s3_ndm1_c;
  logic signed [TEMP_W-1:0]  s3_t;
  logic                      s3_neg;
  logic                      s3_thou;
  logic [9:0]                s3_rem;
  logic [1:0]                s3_ndm1;

  always_comb begin
    s3_mag12  = s2_t[TEMP_W-1] ? (12'd0 - s2_t) : s2_t;
    s3_mag    = s3_mag12[10:0];
    s3_thou_c = s3_mag >= 11'd1000;
    priority if (s3_thou_c)           s3_ndm1_c = 2'd3;
    else if (s3_mag >= 11'd100)       s3_ndm1_c = 2'd2;
    else if (s3_mag >= 11'd10)        s3_ndm1_c = 2'd1;
    else                              s3_ndm1_c = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (advance[3]) begin
      s3_t    <= s2_t;
      s3_neg  <= s2_t[TEMP_W-1];
      s3_thou <= s3_thou_c;
      s3_rem  <= s3_thou_c ? 10'(s3_mag - 11'd1000) : s3_mag[9:0];
      s3_ndm1 <= s3_ndm1_c;
    end
  end

  // stage 4: hundreds digit, exact for values below 1000
  logic [15:0]               s4_prod;
  logic [DIGIT_W-1:0]        s4_hund_c;
  logic [9:0]                s4_hx;
  logic signed [TEMP_W-1:0]  s4_t;
  logic                      s4_neg;
  logic                      s4_thou;
  logic [DIGIT_W-1:0]        s4_hund;
  logic [6:0]                s4_rem2;
  logic [1:0]                s4_ndm1;

  always_comb begin
    s4_prod   = 16'(s3_rem) * 16'd41;
    s4_hund_c = s4_prod[15:12];
    s4_hx     = 10'(s4_hund_c) * 10'd100;
  end

  always_ff @(posedge clk) begin
    if (advance[4]) begin
      s4_t    <= s3_t;
      s4_neg  <= s3_neg;
      s4_thou <= s3_thou;
      s4_hund <= s4_hund_c;
      s4_rem2 <= 7'(s3_rem - s4_hx);
      s4_ndm1 <= s3_ndm1;
    end
  end

  // stage 5: tens and units
  logic [14:0]               s5_prod;
  logic [DIGIT_W-1:0]        s5_tens_c;
  logic [6:0]                s5_tx;
  logic signed [TEMP_W-1:0]  s5_t;
  logic                      s5_neg;
  logic [DIGIT_W-1:0]        s5_thou;
  logic [DIGIT_W-1:0]        s5_hund;
  logic [DIGIT_W-1:0]        s5_tens;
  logic [DIGIT_W-1:0]        s5_units;
  logic [1:0]                s5_ndm1;

  always_comb begin
    s5_prod   = 15'(s4_rem2) * 15'd205;
    s5_tens_c = s5_prod[14:11];
    s5_tx     = 7'(s5_tens_c) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (advance[5]) begin
      s5_t     <= s4_t;
      s5_neg   <= s4_neg;
      s5_thou  <= DIGIT_W'(s4_thou);
      s5_hund  <= s4_hund;
      s5_tens  <= s5_tens_c;
      s5_units <= 4'(s4_rem2 - s5_tx);
      s5_ndm1  <= s4_ndm1;
    end
  end

  // stage 6: place characters rightmost first, minus right after the digits
  logic [DIGIT_W-1:0] dig  [DIGITS];
  logic [SEG_W-1:0]   text [DIGITS];
  logic [SEG_W-1:0]   disp [DIGITS];
  logic [2:0]         nd;

  always_comb begin
    dig[0] = s5_units;
    dig[1] = s5_tens;
    dig[2] = s5_hund;
    dig[3] = s5_thou;
    nd     = {1'b0, s5_ndm1} + 3'd1;
    for (int k = 0; k < DIGITS; k++) begin
      priority if (3'(k) < nd)          text[k] = seg_of(dig[k]);
      else if (3'(k) == nd && s5_neg)   text[k] = SEG_MINUS;
      else                              text[k] = SEG_BLANK;
    end
    for (int k = 0; k < DIGITS; k++) begin
      disp[DIGITS-1-k] = text[k];
    end
    // single digit: shift left and put a zero ahead of it
    if (s5_ndm1 == 2'd0) begin
      disp[0] = disp[1];
      disp[1] = disp[2];
      disp[2] = seg_of(4'd0);
    end
    disp[2] = disp[2] | SEG_POINT;
  end

  always_ff @(posedge clk) begin
    if (advance[6]) begin
      display.temperature_tenths <= s5_t;
      display.digit0_segments    <= disp[0];
      display.digit1_segments    <= disp[1];
      display.digit2_segments    <= disp[2];
      display.digit3_segments    <= disp[3];
    end
  end

  assign display.valid = valid[LAST];

  // checks on the pipeline and the formatter
  a_reset_empty: assert property (@(posedge clk) rst |=> !display.valid)
    else $error("display valid right after reset");

  a_point_lit: assert property (@(posedge clk) disable iff (rst)
    display.valid |-> display.digit2_segments[0])
    else $error("decimal point missing on third digit");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    display.valid |-> (display.temperature_tenths >= TEMP_MIN &&
                       display.temperature_tenths <= TEMP_MAX))
    else $error("temperature outside the reachable range");

  a_no_minus_pos: assert property (@(posedge clk) disable iff (rst)
    (display.valid && !display.temperature_tenths[TEMP_W-1]) |->
    (display.digit0_segments != SEG_MINUS && display.digit1_segments != SEG_MINUS))
    else $error("minus sign shown for a non-negative temperature");

endmodule
